[rtl/core/wpsp_pkg.sv]
// Shared types and constants for the WAVE PCM stream parser.
`default_nettype none
package wpsp_pkg;

   // RIFF tags as they sit in a little-endian 32-bit word
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_HEADER = 3'd1,
      ST_NO_FMT     = 3'd2,
      ST_NO_SAMPLES = 3'd3,
      ST_BAD_WIDTH  = 3'd4,
      ST_DATA_EARLY = 3'd5,
      ST_TRUNCATED  = 3'd6
   } status_type;

   // One classified byte, as handed from front to back
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] word;      // last four bytes, this one in the top lane
      logic        pos_is3;
      logic        pos_is7;
      logic        pos_is11;
      logic [31:0] size_ref;  // byte count so far minus eight
      logic        is_riff;
      logic        is_wave;
      logic        is_fmt;
      logic        is_data;
   } item_type;

endpackage
`default_nettype wire

[rtl/core/wpsp_front.sv]
// Front end: takes file bytes, tracks the byte window and position, tags each byte.
`default_nettype none
module wpsp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_last_byte,
   input  wire logic              q_full,
   output logic                   req_stall,
   output logic                   q_push,
   output wpsp_pkg::item_type     q_item
);

   logic [31:0] word_ff, word_in;
   logic [31:0] pos_ff;

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;
   assign word_in   = {req_data_byte, word_ff[31:8]};

   always_comb begin
      q_item           = '0;
      q_item.data_byte = req_data_byte;
      q_item.last_byte = req_last_byte;
      q_item.word      = word_in;
      q_item.pos_is3   = (pos_ff == 32'd3);
      q_item.pos_is7   = (pos_ff == 32'd7);
      q_item.pos_is11  = (pos_ff == 32'd11);
      q_item.size_ref  = pos_ff - 32'd7;
      q_item.is_riff   = (word_in == wpsp_pkg::TAG_RIFF);
      q_item.is_wave   = (word_in == wpsp_pkg::TAG_WAVE);
      q_item.is_fmt    = (word_in == wpsp_pkg::TAG_FMT);
      q_item.is_data   = (word_in == wpsp_pkg::TAG_DATA);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
         pos_ff  <= '0;
      end else if (q_push) begin
         // clear the window at the end of each file
         if (req_last_byte) begin
            word_ff <= '0;
            pos_ff  <= '0;
         end else begin
            word_ff <= word_in;
            pos_ff  <= pos_ff + 32'd1;
         end
      end
   end

endmodule
`default_nettype wire

[rtl/core/wpsp_queue.sv]
// Short queue of classified bytes between front and back.
`default_nettype none
module wpsp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wpsp_pkg::item_type      push_item,
   input  wire logic               pop,
   output logic                    full,
   output logic                    not_empty,
   output wpsp_pkg::item_type      head_item
);

   localparam int PTR_W = (wpsp_pkg::QUEUE_DEPTH > 1) ? $clog2(wpsp_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(wpsp_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(wpsp_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(wpsp_pkg::QUEUE_DEPTH);

   wpsp_pkg::item_type  slot_ff [wpsp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[rtl/core/wpsp_back.sv]
// Back end: chunk walker, fmt capture, sample pairing and end-of-file report.
`default_nettype none
module wpsp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wpsp_pkg::item_type      q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_sample_value,
   output logic                    rsp_sample_valid,
   output logic                    rsp_channel_index,
   output logic                    rsp_chunk_first,
   output logic                    rsp_done_res,
   output logic [2:0]              rsp_status,
   output logic [1:0]              rsp_num_channels,
   output logic [31:0]             rsp_sample_rate,
   output logic [30:0]             rsp_frame_count
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_CHDR   = 2'd1,
      PH_BODY   = 2'd2,
      PH_PAD    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_FMT   = 2'd1,
      KIND_DATA  = 2'd2
   } kind_type;

   localparam logic [4:0] HDR_KIND_AT  = 5'd3;
   localparam logic [4:0] HDR_SIZE_AT  = 5'd7;
   localparam logic [4:0] FMT_TAG_AT   = 5'd1;
   localparam logic [4:0] FMT_CHAN_AT  = 5'd3;
   localparam logic [4:0] FMT_RATE_AT  = 5'd7;
   localparam logic [4:0] FMT_WIDTH_AT = 5'd15;

   // parser state
   phase_type            phase_ff, phase_in;
   kind_type             kind_ff, kind_in;
   logic                 header_ok_ff, header_ok_in;
   logic [31:0]          declared_ff, declared_in;
   logic [31:0]          remaining_ff, remaining_in;
   logic [4:0]           offset_ff, offset_in;
   logic                 pad_ff, pad_in;
   logic                 fmt_valid_ff, fmt_valid_in;
   logic [1:0]           fmt_ch_ff, fmt_ch_in;
   logic [31:0]          fmt_rate_ff, fmt_rate_in;
   logic                 fmt_w16_ff, fmt_w16_in;
   logic                 data_nz_ff, data_nz_in;
   logic [31:0]          limit_ff, limit_in;
   logic [31:0]          emitted_ff, emitted_in;
   logic [7:0]           low_ff, low_in;
   wpsp_pkg::status_type err_ff, err_in;
   logic                 stg_tag_ok_ff, stg_tag_ok_in;
   logic                 stg_ch_ok_ff, stg_ch_ok_in;
   logic [1:0]           stg_ch_ff, stg_ch_in;
   logic [31:0]          stg_rate_ff, stg_rate_in;
   logic [30:0]          frames_ff, frames_in;

   // result register
   logic                 rsp_valid_ff;
   logic signed [15:0]   rsp_value_ff, res_value;
   logic                 rsp_svalid_ff, res_svalid;
   logic                 rsp_chan_ff, res_chan;
   logic                 rsp_first_ff, res_first;
   logic                 rsp_done_ff;
   wpsp_pkg::status_type rsp_status_ff, res_status;
   logic [1:0]           rsp_count_ff, res_count;
   logic [31:0]          rsp_rate_ff, res_rate;
   logic [30:0]          rsp_frames_ff, res_frames;

   logic                 truncated;
   logic                 ch2;

   assign q_pop = q_valid & (~rsp_valid_ff | ~rsp_stall);
   assign ch2   = (fmt_ch_ff == 2'd2);

   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      header_ok_in  = header_ok_ff;
      declared_in   = declared_ff;
      remaining_in  = remaining_ff;
      offset_in     = offset_ff;
      pad_in        = pad_ff;
      fmt_valid_in  = fmt_valid_ff;
      fmt_ch_in     = fmt_ch_ff;
      fmt_rate_in   = fmt_rate_ff;
      fmt_w16_in    = fmt_w16_ff;
      data_nz_in    = data_nz_ff;
      limit_in      = limit_ff;
      emitted_in    = emitted_ff;
      low_in        = low_ff;
      err_in        = err_ff;
      stg_tag_ok_in = stg_tag_ok_ff;
      stg_ch_ok_in  = stg_ch_ok_ff;
      stg_ch_in     = stg_ch_ff;
      stg_rate_in   = stg_rate_ff;
      frames_in     = frames_ff;
      res_value     = '0;
      res_svalid    = 1'b0;
      res_chan      = 1'b0;
      res_first     = 1'b0;
      res_status    = wpsp_pkg::ST_OK;
      res_count     = '0;
      res_rate      = '0;
      res_frames    = '0;
      truncated     = 1'b0;

      unique case (phase_ff)
         PH_HEADER: begin
            if (q_item.pos_is3) begin
               header_ok_in = q_item.is_riff;
            end else if (q_item.pos_is7) begin
               declared_in = q_item.word;
            end else if (q_item.pos_is11) begin
               header_ok_in = header_ok_ff & q_item.is_wave;
               phase_in     = PH_CHDR;
               offset_in    = '0;
            end
         end
         PH_CHDR: begin
            if (offset_ff == HDR_KIND_AT) begin
               kind_in = q_item.is_fmt  ? KIND_FMT  :
                         q_item.is_data ? KIND_DATA : KIND_OTHER;
            end
            if (offset_ff == HDR_SIZE_AT) begin
               remaining_in = q_item.word;
               pad_in       = q_item.word[0];
               offset_in    = '0;
               if (kind_ff == KIND_DATA) begin
                  data_nz_in = (q_item.word != '0);
                  emitted_in = '0;
                  if (!fmt_valid_ff) begin
                     err_in    = wpsp_pkg::ST_DATA_EARLY;
                     frames_in = '0;
                  end else if (!fmt_w16_ff) begin
                     err_in    = wpsp_pkg::ST_BAD_WIDTH;
                     frames_in = '0;
                  end else begin
                     err_in    = wpsp_pkg::ST_OK;
                     frames_in = ch2 ? {1'b0, q_item.word[31:2]} : q_item.word[31:1];
                  end
                  limit_in = ch2 ? {frames_in, 1'b0} : {1'b0, frames_in};
               end
               phase_in = (q_item.word == '0) ? PH_CHDR : PH_BODY;
            end else begin
               offset_in = offset_ff + 5'd1;
            end
         end
         PH_BODY: begin
            if (kind_ff == KIND_FMT) begin
               // only the first sixteen body bytes matter
               if (!offset_ff[4]) begin
                  if (offset_ff == FMT_TAG_AT) begin
                     stg_tag_ok_in = (q_item.word[31:16] == 16'd1);
                  end else if (offset_ff == FMT_CHAN_AT) begin
                     stg_ch_ok_in = (q_item.word[31:16] == 16'd1) ||
                                    (q_item.word[31:16] == 16'd2);
                     stg_ch_in    = q_item.word[17:16];
                  end else if (offset_ff == FMT_RATE_AT) begin
                     stg_rate_in = q_item.word;
                  end else if (offset_ff == FMT_WIDTH_AT) begin
                     if (stg_tag_ok_ff && stg_ch_ok_ff) begin
                        fmt_valid_in = 1'b1;
                        fmt_ch_in    = stg_ch_ff;
                        fmt_rate_in  = stg_rate_ff;
                        fmt_w16_in   = (q_item.word[31:16] == 16'd16);
                     end
                  end
                  offset_in = offset_ff + 5'd1;
               end
            end else if (kind_ff == KIND_DATA) begin
               if (!offset_ff[0]) begin
                  low_in = q_item.data_byte;
               end else if (emitted_ff < limit_ff) begin
                  res_value  = {q_item.data_byte, low_ff};
                  res_svalid = 1'b1;
                  res_chan   = ch2 & emitted_ff[0];
                  res_first  = (emitted_ff == '0);
                  emitted_in = emitted_ff + 32'd1;
               end
               offset_in = {offset_ff[4:1], ~offset_ff[0]};
            end
            remaining_in = remaining_ff - 32'd1;
            if (remaining_ff == 32'd1) begin
               phase_in  = pad_ff ? PH_PAD : PH_CHDR;
               offset_in = '0;
            end
         end
         PH_PAD: begin
            phase_in  = PH_CHDR;
            offset_in = '0;
         end
      endcase

      if (q_item.last_byte) begin
         truncated = (phase_in == PH_BODY) || ((phase_in == PH_CHDR) && (offset_in != '0));
         priority if ((phase_in == PH_HEADER) || !header_ok_in ||
                      (declared_in != q_item.size_ref)) begin
            res_status = wpsp_pkg::ST_BAD_HEADER;
         end else if (truncated) begin
            res_status = wpsp_pkg::ST_TRUNCATED;
         end else if (!fmt_valid_in) begin
            res_status = wpsp_pkg::ST_NO_FMT;
         end else if (!data_nz_in) begin
            res_status = wpsp_pkg::ST_NO_SAMPLES;
         end else begin
            res_status = err_in;
         end
         res_count  = fmt_valid_in ? fmt_ch_in : 2'd0;
         res_rate   = fmt_valid_in ? fmt_rate_in : 32'd0;
         res_frames = frames_in;

         // back to the start-of-file state for the next file
         phase_in      = PH_HEADER;
         kind_in       = KIND_OTHER;
         header_ok_in  = 1'b0;
         declared_in   = '0;
         remaining_in  = '0;
         offset_in     = '0;
         pad_in        = 1'b0;
         fmt_valid_in  = 1'b0;
         fmt_ch_in     = '0;
         fmt_rate_in   = '0;
         fmt_w16_in    = 1'b0;
         data_nz_in    = 1'b0;
         limit_in      = '0;
         emitted_in    = '0;
         low_in        = '0;
         err_in        = wpsp_pkg::ST_OK;
         stg_tag_ok_in = 1'b0;
         stg_ch_ok_in  = 1'b0;
         stg_ch_in     = '0;
         stg_rate_in   = '0;
         frames_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         kind_ff       <= KIND_OTHER;
         header_ok_ff  <= 1'b0;
         declared_ff   <= '0;
         remaining_ff  <= '0;
         offset_ff     <= '0;
         pad_ff        <= 1'b0;
         fmt_valid_ff  <= 1'b0;
         fmt_ch_ff     <= '0;
         fmt_rate_ff   <= '0;
         fmt_w16_ff    <= 1'b0;
         data_nz_ff    <= 1'b0;
         limit_ff      <= '0;
         emitted_ff    <= '0;
         low_ff        <= '0;
         err_ff        <= wpsp_pkg::ST_OK;
         stg_tag_ok_ff <= 1'b0;
         stg_ch_ok_ff  <= 1'b0;
         stg_ch_ff     <= '0;
         stg_rate_ff   <= '0;
         frames_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (q_pop) begin
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         header_ok_ff  <= header_ok_in;
         declared_ff   <= declared_in;
         remaining_ff  <= remaining_in;
         offset_ff     <= offset_in;
         pad_ff        <= pad_in;
         fmt_valid_ff  <= fmt_valid_in;
         fmt_ch_ff     <= fmt_ch_in;
         fmt_rate_ff   <= fmt_rate_in;
         fmt_w16_ff    <= fmt_w16_in;
         data_nz_ff    <= data_nz_in;
         limit_ff      <= limit_in;
         emitted_ff    <= emitted_in;
         low_ff        <= low_in;
         err_ff        <= err_in;
         stg_tag_ok_ff <= stg_tag_ok_in;
         stg_ch_ok_ff  <= stg_ch_ok_in;
         stg_ch_ff     <= stg_ch_in;
         stg_rate_ff   <= stg_rate_in;
         frames_ff     <= frames_in;
         rsp_valid_ff  <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, loaded on every pop
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_value_ff  <= res_value;
         rsp_svalid_ff <= res_svalid;
         rsp_chan_ff   <= res_chan;
         rsp_first_ff  <= res_first;
         rsp_done_ff   <= q_item.last_byte;
         rsp_status_ff <= res_status;
         rsp_count_ff  <= res_count;
         rsp_rate_ff   <= res_rate;
         rsp_frames_ff <= res_frames;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_value  = rsp_value_ff;
   assign rsp_sample_valid  = rsp_svalid_ff;
   assign rsp_channel_index = rsp_chan_ff;
   assign rsp_chunk_first   = rsp_first_ff;
   assign rsp_done_res      = rsp_done_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_num_channels  = rsp_count_ff;
   assign rsp_sample_rate   = rsp_rate_ff;
   assign rsp_frame_count   = rsp_frames_ff;

   a_emit_within_limit: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= limit_ff)
      else $error("samples emitted beyond data chunk limit");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_item.last_byte |=> phase_ff == PH_HEADER && !fmt_valid_ff)
      else $error("parser not restarted after last byte");

   a_pop_loads_result: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid_ff)
      else $error("popped byte produced no result");

   a_report_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_done_ff |->
         rsp_status_ff == wpsp_pkg::ST_OK && rsp_count_ff == 2'd0 && rsp_rate_ff == '0)
      else $error("end-of-file report fields set mid-file");

endmodule
`default_nettype wire

[rtl/core/wav_pcm_stream_parser_unit.sv]
// Top level of the WAVE PCM stream parser: front end, byte queue and parser back end.
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_stall  data_byte, last_byte
//  rsp_     out        rsp_valid/rsp_stall  sample_value .. frame_count (one per byte)
//
//  One byte per cycle sustained while rsp_stall is low; each byte gives exactly one result.
//  A taken byte passes through a queue slot and then the result register before its result appears.
//  The back end decodes a whole byte combinationally; the two-entry queue sets the slack.
//  Reset is synchronous and active high.
//  req_stall rises only when the queue is full, which happens only under rsp_stall
//  with bytes still arriving.
`default_nettype none
module wav_pcm_stream_parser_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_data_byte,
   input  wire logic          req_last_byte,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic signed [15:0] rsp_sample_value,
   output logic               rsp_sample_valid,
   output logic               rsp_channel_index,
   output logic               rsp_chunk_first,
   output logic               rsp_done_res,
   output logic [2:0]         rsp_status,
   output logic [1:0]         rsp_num_channels,
   output logic [31:0]        rsp_sample_rate,
   output logic [30:0]        rsp_frame_count
);

   wpsp_pkg::item_type push_item;
   wpsp_pkg::item_type head_item;
   logic               q_push;
   logic               q_full;
   logic               q_not_empty;
   logic               q_pop;

   wpsp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .req_stall     (req_stall),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   wpsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   wpsp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_not_empty),
      .q_item            (head_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_sample_valid  (rsp_sample_valid),
      .rsp_channel_index (rsp_channel_index),
      .rsp_chunk_first   (rsp_chunk_first),
      .rsp_done_res      (rsp_done_res),
      .rsp_status        (rsp_status),
      .rsp_num_channels  (rsp_num_channels),
      .rsp_sample_rate   (rsp_sample_rate),
      .rsp_frame_count   (rsp_frame_count)
   );

endmodule
`default_nettype wire
